// ===== hw/rtl/dcrq_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrq_pkg
// shared constants, types and helpers for the distinct count range query block
// ----------------------------------------------------------------------------
package dcrq_pkg;

  localparam int MaxN      = 1024;
  localparam int ValueBits = 16;
  localparam int PosW      = $clog2(MaxN + 1);
  localparam int AddrW     = $clog2(MaxN);
  localparam int IdxW      = PosW + 1;
  localparam int ValueW    = 16;
  localparam int TagW      = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RANGE = 3'd1,
    ST_ORDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_PHASE     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_REJECT,
    CMD_B_START,
    CMD_B_RDE,
    CMD_B_RDL,
    CMD_B_LAT,
    CMD_B_CMP,
    CMD_B_WR0,
    CMD_B_WRP,
    CMD_B_NEXT,
    CMD_B_DONE,
    CMD_M_RD,
    CMD_M_WR,
    CMD_S_RD,
    CMD_S_LD,
    CMD_S_DEC,
    CMD_P_INIT,
    CMD_P_RD,
    CMD_P_ADD,
    CMD_P_SWAP,
    CMD_P_DONE,
    CMD_OUT
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_B_START,
    S_B_CHK,
    S_B_V,
    S_B_L,
    S_B_E,
    S_B_W0,
    S_B_WP,
    S_B_NEXT,
    S_M_CHK,
    S_M_WR,
    S_S_CHK,
    S_S_LD,
    S_S_DEC,
    S_P_CHK,
    S_P_ADD,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e st;
  } ctrl_t;

  typedef struct packed {
    op_e  op;
    logic last;
    logic built;
    logic full;
    logic range_bad;
    logic order_bad;
    logic pos_zero;
    logic cand;
    logic hit;
    logic idx_ok;
    logic idx_zero;
    logic sp_gt_r;
    logic prev_nz;
  } flags_t;

  function automatic logic [IdxW-1:0] lsb(input logic [IdxW-1:0] x);
    lsb = x & (~x + IdxW'(1));
  endfunction

endpackage

// ===== hw/rtl/distinct_count_range_query.sv =====
// ----------------------------------------------------------------------------
// distinct_count_range_query
// distinct value counter over position ranges, offline fenwick sweep
// ----------------------------------------------------------------------------
// One word at a time, one result word per input word. The load flagged last
// also runs the build pass over all stored elements, touching fenwick parents
// as it goes. A query moves the sweep pointer down to the right bound, marks
// each previous occurrence it finds and updates the fenwick nodes for that
// mark, then runs the two prefix walks. A result word not yet taken holds the
// block before its next result. No clearing pass is needed after reset or
// clear.
module distinct_count_range_query (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] value_i,
  input  logic        last_element_i,
  input  logic [10:0] left_pos_i,
  input  logic [10:0] right_pos_i,
  input  logic [15:0] query_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] distinct_count_o,
  output logic [15:0] tag_out_o,
  output logic [2:0]  status_o
);
  import dcrq_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  dcrq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ctrl_o(ctrl), .flags_i(flags)
  );

  dcrq_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .flags_o(flags),
    .operation_i, .value_i, .last_element_i, .left_pos_i, .right_pos_i,
    .query_tag_i, .distinct_count_o, .tag_out_o, .status_o
  );

endmodule

// ===== hw/rtl/dcrq_ram.sv =====
// ----------------------------------------------------------------------------
// dcrq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dcrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dcrq_datapath.sv =====
// ----------------------------------------------------------------------------
// dcrq_datapath
// element, link, last seen and fenwick stores with the registers that walk them
// ----------------------------------------------------------------------------
module dcrq_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dcrq_pkg::ctrl_t         ctrl_i,
  output dcrq_pkg::flags_t        flags_o,
  input  logic [1:0]              operation_i,
  input  logic [15:0]             value_i,
  input  logic                    last_element_i,
  input  logic [10:0]             left_pos_i,
  input  logic [10:0]             right_pos_i,
  input  logic [15:0]             query_tag_i,
  output logic [10:0]             distinct_count_o,
  output logic [15:0]             tag_out_o,
  output logic [2:0]              status_o
);
  import dcrq_pkg::*;

  op_e                  op_q;
  logic [ValueW-1:0]    vin_q;
  logic                 last_q;
  logic [PosW-1:0]      l_q, r_q;
  logic [TagW-1:0]      tag_q;
  logic [PosW-1:0]      cnt_q, sp_q, pos_q, later_q, acc_q, suma_q, res_cnt_q;
  logic                 built_q, hit_q;
  logic [IdxW-1:0]      idx_q;
  logic [ValueBits-1:0] val_q;
  status_e              res_st_q;
  logic [PosW-1:0]      dcnt_q;
  logic [TagW-1:0]      otag_q;
  status_e              ost_q;

  logic                 e_we, e_re, l_we, l_re, p_we, p_re, f_we, f_re;
  logic [AddrW-1:0]     e_wa, e_ra, p_wa, f_wa;
  logic [ValueBits-1:0] e_rd, l_ra, l_wa;
  logic [PosW-1:0]      l_rd, p_rd, p_wd, f_rd, f_wd;
  logic [PosW-1:0]      cnt_inc;
  logic                 cand;

  assign cnt_inc    = cnt_q + PosW'(1);
  assign cand       = (l_rd > pos_q) && (l_rd <= cnt_q);

  always_comb begin
    e_we = (ctrl_i.cmd == CMD_LOAD) && (cnt_q != PosW'(MaxN));
    e_wa = cnt_inc[AddrW-1:0];
    e_re = (ctrl_i.cmd == CMD_B_RDE) || ((ctrl_i.cmd == CMD_B_LAT) && cand);
    e_ra = (ctrl_i.cmd == CMD_B_RDE) ? pos_q[AddrW-1:0] : l_rd[AddrW-1:0];
    l_re = (ctrl_i.cmd == CMD_B_RDL);
    l_ra = e_rd;
    l_we = (ctrl_i.cmd == CMD_B_WR0);
    l_wa = val_q;
    p_re = (ctrl_i.cmd == CMD_S_RD);
    p_we = (ctrl_i.cmd == CMD_B_WR0) || (ctrl_i.cmd == CMD_B_WRP);
    p_wa = (ctrl_i.cmd == CMD_B_WR0) ? pos_q[AddrW-1:0] : later_q[AddrW-1:0];
    p_wd = (ctrl_i.cmd == CMD_B_WR0) ? '0 : pos_q;
    f_re = (ctrl_i.cmd == CMD_M_RD) || (ctrl_i.cmd == CMD_P_RD);
    f_we = (ctrl_i.cmd == CMD_B_WR0) || (ctrl_i.cmd == CMD_M_WR);
    f_wa = (ctrl_i.cmd == CMD_B_WR0) ? pos_q[AddrW-1:0] : idx_q[AddrW-1:0];
    f_wd = (ctrl_i.cmd == CMD_B_WR0) ? PosW'(!hit_q) : f_rd + PosW'(1);
  end

  dcrq_ram #(.Width(ValueBits), .Depth(MaxN)) u_elem (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(vin_q[ValueBits-1:0]),
    .re_i(e_re), .raddr_i(e_ra), .rdata_o(e_rd)
  );

  dcrq_ram #(.Width(PosW), .Depth(2 ** ValueBits)) u_last (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(pos_q),
    .re_i(l_re), .raddr_i(l_ra), .rdata_o(l_rd)
  );

  dcrq_ram #(.Width(PosW), .Depth(MaxN)) u_prev (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(p_re), .raddr_i(sp_q[AddrW-1:0]), .rdata_o(p_rd)
  );

  dcrq_ram #(.Width(PosW), .Depth(MaxN)) u_fen (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd),
    .re_i(f_re), .raddr_i(idx_q[AddrW-1:0]), .rdata_o(f_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sp_q    <= '0;
      built_q <= 1'b0;
    end else begin
      unique case (ctrl_i.cmd)
        CMD_CLEAR: begin
          cnt_q   <= '0;
          sp_q    <= '0;
          built_q <= 1'b0;
        end
        CMD_LOAD: begin
          if (cnt_q != PosW'(MaxN)) begin
            cnt_q <= cnt_inc;
          end
        end
        CMD_B_DONE: begin
          sp_q    <= cnt_q;
          built_q <= 1'b1;
        end
        CMD_S_DEC: sp_q <= sp_q - PosW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_CAPTURE: begin
        op_q   <= op_e'(operation_i);
        vin_q  <= value_i;
        last_q <= last_element_i;
        l_q    <= left_pos_i;
        r_q    <= right_pos_i;
        tag_q  <= query_tag_i;
      end
      CMD_CLEAR: begin
        res_cnt_q <= '0;
        res_st_q  <= ST_OK;
      end
      CMD_LOAD: begin
        res_cnt_q <= '0;
        res_st_q  <= (cnt_q == PosW'(MaxN)) ? ST_FULL : ST_OK;
      end
      CMD_REJECT: begin
        res_cnt_q <= '0;
        res_st_q  <= ctrl_i.st;
      end
      CMD_B_START: pos_q <= cnt_q;
      CMD_B_RDL:   val_q <= e_rd;
      CMD_B_LAT: begin
        later_q <= l_rd;
        hit_q   <= 1'b0;
      end
      CMD_B_CMP:  hit_q <= (e_rd == val_q);
      CMD_B_WR0:  idx_q <= {1'b0, pos_q} + lsb({1'b0, pos_q});
      CMD_B_NEXT: pos_q <= pos_q - PosW'(1);
      CMD_M_WR:   idx_q <= idx_q + lsb(idx_q);
      CMD_S_LD:   idx_q <= {1'b0, p_rd};
      CMD_P_INIT: begin
        acc_q <= '0;
        idx_q <= {1'b0, r_q};
      end
      CMD_P_ADD: begin
        acc_q <= acc_q + f_rd;
        idx_q <= idx_q - lsb(idx_q);
      end
      CMD_P_SWAP: begin
        suma_q <= acc_q;
        acc_q  <= '0;
        idx_q  <= {1'b0, l_q - PosW'(1)};
      end
      CMD_P_DONE: begin
        res_cnt_q <= suma_q - acc_q;
        res_st_q  <= ST_OK;
      end
      CMD_OUT: begin
        dcnt_q <= res_cnt_q;
        otag_q <= (op_q == OP_QUERY) ? tag_q : '0;
        ost_q  <= res_st_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    flags_o.op        = op_q;
    flags_o.last      = last_q;
    flags_o.built     = built_q;
    flags_o.full      = (cnt_q == PosW'(MaxN));
    flags_o.range_bad = (l_q == '0) || (r_q < l_q) || (r_q > cnt_q);
    flags_o.order_bad = (r_q > sp_q);
    flags_o.pos_zero  = (pos_q == '0);
    flags_o.cand      = cand;
    flags_o.hit       = hit_q;
    flags_o.idx_ok    = (idx_q != '0) && (idx_q <= {1'b0, cnt_q});
    flags_o.idx_zero  = (idx_q == '0);
    flags_o.sp_gt_r   = (sp_q > r_q);
    flags_o.prev_nz   = (p_rd != '0);
  end

  assign distinct_count_o = dcnt_q;
  assign tag_out_o        = otag_q;
  assign status_o         = ost_q;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PosW'(MaxN)) else $error("element count beyond capacity");
  a_sp_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= cnt_q) else $error("sweep pointer beyond element count");
  a_sp_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd != CMD_B_DONE |=> sp_q <= $past(sp_q))
    else $error("sweep pointer moved up outside build");
`endif

endmodule

// ===== hw/rtl/dcrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcrq_ctrl
// sequencer for load, build, sweep and prefix walks, and the output handshake
// ----------------------------------------------------------------------------
module dcrq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dcrq_pkg::ctrl_t  ctrl_o,
  input  dcrq_pkg::flags_t flags_i
);
  import dcrq_pkg::*;

  state_e state_q, state_d;
  logic   mret_q, mret_d;
  logic   second_q, second_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mret_q   <= 1'b0;
      second_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mret_q   <= mret_d;
      second_q <= second_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mret_d      = mret_q;
    second_d    = second_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    ctrl_o.cmd  = CMD_NOP;
    ctrl_o.st   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_CAPTURE;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_RESP;
        unique case (flags_i.op)
          OP_CLEAR: ctrl_o.cmd = CMD_CLEAR;
          OP_LOAD: begin
            if (flags_i.built) begin
              ctrl_o.cmd = CMD_REJECT;
              ctrl_o.st  = ST_PHASE;
            end else begin
              ctrl_o.cmd = CMD_LOAD;
              if (flags_i.last) begin
                state_d = S_B_START;
              end
            end
          end
          OP_QUERY: begin
            priority if (!flags_i.built) begin
              ctrl_o.cmd = CMD_REJECT;
              ctrl_o.st  = ST_PHASE;
            end else if (flags_i.range_bad) begin
              ctrl_o.cmd = CMD_REJECT;
              ctrl_o.st  = ST_BAD_RANGE;
            end else if (flags_i.order_bad) begin
              ctrl_o.cmd = CMD_REJECT;
              ctrl_o.st  = ST_ORDER;
            end else begin
              state_d = S_S_CHK;
            end
          end
          default: ctrl_o.cmd = CMD_REJECT;
        endcase
      end
      S_B_START: begin
        ctrl_o.cmd = CMD_B_START;
        state_d    = S_B_CHK;
      end
      S_B_CHK: begin
        if (flags_i.pos_zero) begin
          ctrl_o.cmd = CMD_B_DONE;
          state_d    = S_RESP;
        end else begin
          ctrl_o.cmd = CMD_B_RDE;
          state_d    = S_B_V;
        end
      end
      S_B_V: begin
        ctrl_o.cmd = CMD_B_RDL;
        state_d    = S_B_L;
      end
      S_B_L: begin
        ctrl_o.cmd = CMD_B_LAT;
        state_d    = flags_i.cand ? S_B_E : S_B_W0;
      end
      S_B_E: begin
        ctrl_o.cmd = CMD_B_CMP;
        state_d    = S_B_W0;
      end
      S_B_W0: begin
        ctrl_o.cmd = CMD_B_WR0;
        mret_d     = 1'b0;
        state_d    = flags_i.hit ? S_B_WP : S_M_CHK;
      end
      S_B_WP: begin
        ctrl_o.cmd = CMD_B_WRP;
        state_d    = S_B_NEXT;
      end
      S_B_NEXT: begin
        ctrl_o.cmd = CMD_B_NEXT;
        state_d    = S_B_CHK;
      end
      S_M_CHK: begin
        if (flags_i.idx_ok) begin
          ctrl_o.cmd = CMD_M_RD;
          state_d    = S_M_WR;
        end else begin
          state_d = mret_q ? S_S_DEC : S_B_NEXT;
        end
      end
      S_M_WR: begin
        ctrl_o.cmd = CMD_M_WR;
        state_d    = S_M_CHK;
      end
      S_S_CHK: begin
        if (flags_i.sp_gt_r) begin
          ctrl_o.cmd = CMD_S_RD;
          state_d    = S_S_LD;
        end else begin
          ctrl_o.cmd = CMD_P_INIT;
          second_d   = 1'b0;
          state_d    = S_P_CHK;
        end
      end
      S_S_LD: begin
        if (flags_i.prev_nz) begin
          ctrl_o.cmd = CMD_S_LD;
          mret_d     = 1'b1;
          state_d    = S_M_CHK;
        end else begin
          state_d = S_S_DEC;
        end
      end
      S_S_DEC: begin
        ctrl_o.cmd = CMD_S_DEC;
        state_d    = S_S_CHK;
      end
      S_P_CHK: begin
        priority if (!flags_i.idx_zero) begin
          ctrl_o.cmd = CMD_P_RD;
          state_d    = S_P_ADD;
        end else if (!second_q) begin
          ctrl_o.cmd = CMD_P_SWAP;
          second_d   = 1'b1;
        end else begin
          ctrl_o.cmd = CMD_P_DONE;
          state_d    = S_RESP;
        end
      end
      S_P_ADD: begin
        ctrl_o.cmd = CMD_P_ADD;
        state_d    = S_P_CHK;
      end
      S_RESP: begin
        if (out_free) begin
          ctrl_o.cmd = CMD_OUT;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISPATCH)
    else $error("accepted word not dispatched");
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && out_free |=> out_valid_o && state_q == S_IDLE)
    else $error("result not presented");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
`endif

endmodule
